// ----- hw/rtl/ita_pkg.sv -----
// ----------------------------------------------------------------------------
// ita_pkg
// Shared constants, types and helpers of the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

   localparam int MAX_WIDTH_DEFAULT = 32;

   localparam int VALUE_BITS  = 64;
   localparam int HALF_BITS   = 32;
   localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
   localparam int DIGIT_SLOTS = 20;
   localparam int DIGIT_BITS  = 4;
   localparam int BCD_BITS    = DIGIT_SLOTS * DIGIT_BITS;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_SLOTS);
   localparam int FW_BITS     = 6;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] LOWER_BASE = 8'h61 - 8'd10;
   localparam logic [7:0] UPPER_BASE = 8'h41 - 8'd10;

   typedef struct packed {
      logic                   done;
      logic                   neg;
      logic [DIGIT_IDX_W-1:0] msd;
   } conv_stat_type;

   typedef struct packed {
      logic               upper;
      logic               fill;
      logic [FW_BITS-1:0] width;
   } fmt_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                             input logic upper);
      logic [7:0] dx;
      dx = {{(8-DIGIT_BITS){1'b0}}, d};
      if (d >= DIGIT_BITS'(10)) begin
         return dx + (upper ? UPPER_BASE : LOWER_BASE);
      end
      return dx + CHAR_ZERO;
   endfunction

endpackage

// ----- hw/rtl/ita_convert.sv -----
// ----------------------------------------------------------------------------
// ita_convert
// Bit-serial binary to BCD (or nibble) converter with leading-digit tracking.
// ----------------------------------------------------------------------------
module ita_convert (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ita_pkg::VALUE_BITS-1:0] value,
   input  logic                          wide,
   input  logic                          hex,
   input  logic                          uns,
   output ita_pkg::conv_stat_type         stat,
   output logic [ita_pkg::BCD_BITS-1:0]   bcd
);
   import ita_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]  bin_ff, bin_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]    bcd_adj;
   logic [DIGIT_IDX_W-1:0] msd_ff, msd_in;
   logic [DIGIT_IDX_W-1:0] msd_up;
   logic                   neg_ff, neg_in;
   logic                   hex_ff, hex_in;
   logic                   sign_src;
   logic                   neg_now;
   logic [VALUE_BITS-1:0]  mag;

   // Magnitude of the argument at its own width.
   always_comb begin
      sign_src = wide ? value[VALUE_BITS-1] : value[HALF_BITS-1];
      neg_now  = !uns && !hex && sign_src;
      if (wide) begin
         mag = neg_now ? (~value + VALUE_BITS'(1)) : value;
      end else begin
         mag = {{(VALUE_BITS-HALF_BITS){1'b0}},
                neg_now ? (~value[HALF_BITS-1:0] + HALF_BITS'(1)) : value[HALF_BITS-1:0]};
      end
   end

   // Add-3 correction on every decimal digit before the shift.
   always_comb begin
      logic [DIGIT_BITS-1:0] dg;
      dg = '0;
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         dg = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
            (!hex_ff && dg >= DIGIT_BITS'(5)) ? dg + DIGIT_BITS'(3) : dg;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      msd_in  = msd_ff;
      neg_in  = neg_ff;
      hex_in  = hex_ff;
      msd_up  = msd_ff + DIGIT_IDX_W'(1);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = mag;
         bcd_in  = '0;
         msd_in  = '0;
         neg_in  = neg_now;
         hex_in  = hex;
      end else if (busy_ff) begin
         bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         // Doubling grows the value by at most one digit per step.
         if (msd_ff != DIGIT_IDX_W'(DIGIT_SLOTS-1) &&
             bcd_in[msd_up*DIGIT_BITS +: DIGIT_BITS] != '0) begin
            msd_in = msd_up;
         end
         cnt_in = cnt_ff + BIT_CNT_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      msd_ff <= msd_in;
      neg_ff <= neg_in;
      hex_ff <= hex_in;
   end

   assign stat.done = done_ff;
   assign stat.neg  = neg_ff;
   assign stat.msd  = msd_ff;
   assign bcd       = bcd_ff;

endmodule

// ----- hw/rtl/ita_emit.sv -----
// ----------------------------------------------------------------------------
// ita_emit
// Item sequencer and character emitter with a registered output stage.
// ----------------------------------------------------------------------------
module ita_emit #(
   parameter int MAX_WIDTH = ita_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  ita_pkg::fmt_type                fmt,
   input  ita_pkg::conv_stat_type          stat,
   input  logic [ita_pkg::BCD_BITS-1:0]    bcd,
   output logic                           idle,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ita_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                           rsp_tlast
);
   import ita_pkg::*;

   localparam int PW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (PW > FW_BITS) ? PW : FW_BITS;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CONV = 4'b0010,
      S_PREP = 4'b0100,
      S_SEND = 4'b1000
   } emit_state_type;

   emit_state_type state_ff, state_in;
   fmt_type        fmt_ff, fmt_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic           neg_ff, neg_in;
   logic           fill_ff, fill_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_char_ff, rsp_char_in;
   logic           rsp_last_ff, rsp_last_in;

   logic                  can_step;
   logic                  in_digits;
   logic [DIGIT_BITS-1:0] d;
   logic                  sign_now;
   logic [CW-1:0]         need;
   logic [CW-1:0]         fw_ext;
   logic [CW-1:0]         tot_a;
   logic [CW-1:0]         tot;

   always_comb begin
      can_step  = !rsp_valid_ff || rsp_tready;
      in_digits = pos_ff < PW'(DIGIT_SLOTS);
      d = in_digits ? bcd[pos_ff[DIGIT_IDX_W-1:0]*DIGIT_BITS +: DIGIT_BITS] : '0;
      sign_now = neg_ff && (pos_ff == '0 || fill_ff || d != '0);

      need   = CW'(stat.msd) + CW'(1) + CW'(neg_ff);
      fw_ext = CW'(fmt_ff.width);
      tot_a  = (fw_ext > need) ? fw_ext : need;
      tot    = (tot_a > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : tot_a;
   end

   always_comb begin
      state_in     = state_ff;
      fmt_in       = fmt_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               fmt_in   = fmt;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (stat.done) begin
               neg_in   = stat.neg;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            fill_in  = fmt_ff.fill;
            pos_in   = PW'(tot - CW'(neg_ff) - CW'(1));
            state_in = S_SEND;
         end
         S_SEND: begin
            if (can_step) begin
               rsp_valid_in = 1'b1;
               if (sign_now) begin
                  // The sign takes a slot of its own; the position holds.
                  rsp_char_in = CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  if (d == '0 && !fill_ff && pos_ff != '0) begin
                     rsp_char_in = CHAR_SPACE;
                  end else begin
                     fill_in     = 1'b1;
                     rsp_char_in = digit_char(d, fmt_ff.upper);
                  end
                  rsp_last_in = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     pos_in = pos_ff - PW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff      <= fmt_in;
      pos_ff      <= pos_in;
      fill_ff     <= fill_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> state_ff == S_CONV)
      else $error("conversion finished outside the conversion state");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEND |-> pos_ff < PW'(MAX_WIDTH))
      else $error("character position beyond the field limit");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_char_ff == CHAR_MINUS |-> !rsp_last_ff)
      else $error("sign marked as the final character");

   a_sign_emitted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && state_ff == S_IDLE |-> !neg_ff)
      else $error("number finished with the sign still pending");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEND && can_step && !sign_now && pos_ff == '0 |=>
         state_ff == S_IDLE && rsp_valid_ff && rsp_last_ff)
      else $error("final character did not close the item");

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer as decimal or hexadecimal ASCII, one character per
// output transfer.
// ----------------------------------------------------------------------------
// One number is handled at a time. After the input transfer the magnitude is
// converted bit-serially, one argument bit per cycle over all 64 bits,
// regardless of width or base; the emitter picks up the end of the conversion
// in S_CONV and sizes the field in S_PREP, and then one character leaves per
// cycle that the output is not stalled, up to MAX_WIDTH characters. A new
// number is taken as soon as the last character of the previous one sits in
// the output register.
module integer_to_ascii_formatter #(
   parameter int MAX_WIDTH = ita_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [63:0] value, [64] upper_letters, [65] zero_fill, [71:66] field_width
   input  logic [ita_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] wide_arg, [1] hex_base, [2] unsigned_flag
   input  logic [ita_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] character
   output logic [ita_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import ita_pkg::*;

   logic                  accept;
   logic                  idle;
   fmt_type               fmt;
   conv_stat_type         stat;
   logic [BCD_BITS-1:0]   bcd;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = idle;

   assign fmt.upper = req_tdata[VALUE_BITS];
   assign fmt.fill  = req_tdata[VALUE_BITS+1];
   assign fmt.width = req_tdata[VALUE_BITS+2 +: FW_BITS];

   ita_convert u_convert (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (req_tdata[VALUE_BITS-1:0]),
      .wide  (req_tuser[0]),
      .hex   (req_tuser[1]),
      .uns   (req_tuser[2]),
      .stat  (stat),
      .bcd   (bcd)
   );

   ita_emit #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .fmt        (fmt),
      .stat       (stat),
      .bcd        (bcd),
      .idle       (idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/integer_to_ascii_formatter_checker.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_checker
// Watches both streams of the formatter, works out the characters each
// accepted number must produce and compares every output transfer with them.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_checker #(
   parameter int MAX_WIDTH = ita_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [63:0] value, [64] upper_letters, [65] zero_fill, [71:66] field_width
   input  logic [ita_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] wide_arg, [1] hex_base, [2] unsigned_flag
   input  logic [ita_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] character
   input  logic [ita_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   output int                              mismatch_count,
   output int                              chars_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ita_pkg::*;

   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
   } ascii_char_type;

   ascii_char_type expected_chars[$];

   initial begin
      mismatch_count = 0;
      chars_pending  = 0;
   end

   // Appends the characters that one formatted number must produce.
   function automatic void format_number(input logic [63:0] raw,
                                         input logic wide, input logic hex,
                                         input logic upper, input logic uns_flag,
                                         input logic zero_fill,
                                         input logic [5:0] field_width);
      logic [63:0] mag;
      logic [63:0] lo;
      logic [63:0] base;
      logic [63:0] t;
      logic [63:0] rem;
      logic [3:0]  digits[DIGIT_SLOTS];
      logic [3:0]  d;
      logic [7:0]  ch;
      logic        uns;
      logic        fill;
      logic        neg;
      int          nd;
      int          total;
      int          ndig;
      int          fw;
      ascii_char_type item;

      uns  = uns_flag | hex;
      fill = zero_fill;
      neg  = 1'b0;
      base = hex ? 64'd16 : 64'd10;
      fw   = field_width;
      if (wide) begin
         if (!uns && raw[63]) begin
            neg = 1'b1;
            mag = 64'd0 - raw;
         end else begin
            mag = raw;
         end
      end else begin
         lo = {32'd0, raw[31:0]};
         if (!uns && raw[31]) begin
            neg = 1'b1;
            mag = 64'h1_0000_0000 - lo;
         end else begin
            mag = lo;
         end
      end

      t  = mag;
      nd = 0;
      do begin
         rem = t % base;
         digits[nd] = rem[3:0];
         t = t / base;
         nd++;
      end while (t != 0 && nd < DIGIT_SLOTS);

      total = nd + (neg ? 1 : 0);
      if (fw > total) total = fw;
      if (total > MAX_WIDTH) total = MAX_WIDTH;
      ndig = total - (neg ? 1 : 0);

      for (int p = ndig - 1; p >= 0; p--) begin
         d = (p < nd) ? digits[p] : 4'd0;
         // The sign leads under zero fill, otherwise it sits just before
         // the first significant digit.
         if (neg && (p == 0 || fill || d != 4'd0)) begin
            item.character = CHAR_MINUS;
            item.is_last   = 1'b0;
            expected_chars.push_back(item);
            neg = 1'b0;
         end
         if (d == 4'd0 && !fill && p != 0) begin
            ch = CHAR_SPACE;
         end else begin
            fill = 1'b1;
            if (d >= 4'd10) begin
               ch = {4'd0, d} + (upper ? UPPER_BASE : LOWER_BASE);
            end else begin
               ch = {4'd0, d} + CHAR_ZERO;
            end
         end
         item.character = ch;
         item.is_last   = (p == 0);
         expected_chars.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset) begin
         // Compare first, so a character leaving at the same edge as a new
         // number arrives is matched against the older number.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected character 0x%02h last=%0b",
                           $realtime, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.character || rsp_tlast !== want.is_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: character expected 0x%02h last=%0b, got 0x%02h last=%0b",
                              $realtime, want.character, want.is_last,
                              rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            format_number(req_tdata[63:0], req_tuser[0], req_tuser[1],
                          req_tdata[64], req_tuser[2], req_tdata[65],
                          req_tdata[71:66]);
         end
      end
      chars_pending = expected_chars.size();
   end

endmodule

// ----- test/integer_to_ascii_formatter_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Drives the formatter with directed corner numbers and then random numbers
// and specs under three stall mixes, including one long output hold-off.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ita_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 120;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_PER_MIX = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int mismatch_count;
   int chars_pending;
   int send_idle_pct = 6;
   int recv_idle_pct = 66;
   bit hold_output = 1'b0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   integer_to_ascii_formatter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   integer_to_ascii_formatter_checker u_char_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   // Output side: random back-pressure, plus one long hold-off on request so
   // that the formatter backs up and stops taking numbers.
   always begin
      @(negedge clock);
      if (hold_output) begin
         rsp_tready = 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_output = 1'b0;
      end
      rsp_tready = !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_number(input logic [63:0] value, input logic wide,
                              input logic hex, input logic upper,
                              input logic uns, input logic fill,
                              input logic [5:0] field_width);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {field_width, fill, upper, value};
      req_tuser  = {uns, hex, wide};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [63:0] pick_value();
      logic [63:0] p;
      int          k;
      case ($urandom_range(5))
         0: return {$urandom, $urandom};
         1: return 64'($signed($urandom_range(2000)) - 1000);
         2: begin
            // Values next to a power of ten stress the digit count.
            k = $urandom_range(19);
            p = 64'd1;
            repeat (k) p = p * 64'd10;
            return p + 64'($signed($urandom_range(2)) - 1);
         end
         3: begin
            case ($urandom_range(5))
               0: return 64'h8000_0000_0000_0000;
               1: return 64'h7FFF_FFFF_FFFF_FFFF;
               2: return 64'hFFFF_FFFF_FFFF_FFFF;
               3: return {$urandom, 32'h8000_0000};
               4: return {$urandom, 32'h7FFF_FFFF};
               default: return 64'd0;
            endcase
         end
         4: return {$urandom, 32'($urandom_range(300))};
         default: return {$urandom, $urandom} >> $urandom_range(63);
      endcase
   endfunction

   function automatic logic [5:0] pick_width();
      if ($urandom_range(9) == 0) return 6'($urandom_range(63, 33));
      return 6'($urandom_range(32));
   endfunction

   task automatic send_random(input int count);
      repeat (count) begin
         send_number(pick_value(), 1'($urandom), 1'($urandom), 1'($urandom),
                     1'($urandom), 1'($urandom), pick_width());
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed corners: value, wide, hex, upper, unsigned, fill, width.
      send_number(64'd0,                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
      send_number(64'd0,                   1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 6'd8);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
      send_number(64'h1234_5678_8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
      send_number(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0);
      send_number(64'hABCD_0000_DEAD_BEEF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0);
      send_number(64'hABCD_0000_DEAD_BEEF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 6'd12);
      send_number(-64'sd42,                1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 6'd10);
      send_number(-64'sd42,                1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd10);
      send_number(-64'sd10,                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd5);
      send_number(64'd12345,               1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd63);
      send_number(-64'sd7,                 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 6'd63);
      send_number(64'd5,                   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd1);
      send_number(64'd987654321,           1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd3);
      send_number(64'h0000_0000_8000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0);
      send_number(64'd255,                 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 6'd4);
      send_number(64'hFFFF_FFFF_7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
      send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
      send_number(64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 6'd32);
      send_number(64'd100,                 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 6'd6);
      send_number(-64'sd1,                 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd33);
      send_random(RANDOM_PER_MIX);

      send_idle_pct = 66;
      recv_idle_pct = 6;
      send_random(RANDOM_PER_MIX);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_output   = 1'b1;
      send_random(RANDOM_PER_MIX);

      req_tvalid = 1'b0;
      while (chars_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- integer_to_ascii_formatter.f -----
hw/rtl/ita_pkg.sv
hw/rtl/ita_convert.sv
hw/rtl/ita_emit.sv
hw/rtl/integer_to_ascii_formatter.sv
test/integer_to_ascii_formatter_checker.sv
test/integer_to_ascii_formatter_tb.sv
